// ===== sv/rotation_matrix_to_quaternion_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the rotation matrix to quaternion block
// Clocked on clk, disabled while rst_n is low; one macro per implication form.
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define R2Q_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define R2Q_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/r2q_pkg.sv =====
// ----------------------------------------------------------------------------
// r2q_pkg
// Beat types and path codes shared by the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
package r2q_pkg;

    // Width of one matrix element and one quaternion component
    localparam int ELEM_W = 16;

    // Which branch produced the quaternion
    typedef logic [1:0] path_t;
    localparam path_t PATH_X     = 2'd0;
    localparam path_t PATH_Y     = 2'd1;
    localparam path_t PATH_Z     = 2'd2;
    localparam path_t PATH_TRACE = 2'd3;

    // Input beat: element a(r,c) in field m<r><c>
    typedef struct packed {
        logic signed [ELEM_W-1:0] m00;
        logic signed [ELEM_W-1:0] m01;
        logic signed [ELEM_W-1:0] m02;
        logic signed [ELEM_W-1:0] m10;
        logic signed [ELEM_W-1:0] m11;
        logic signed [ELEM_W-1:0] m12;
        logic signed [ELEM_W-1:0] m20;
        logic signed [ELEM_W-1:0] m21;
        logic signed [ELEM_W-1:0] m22;
    } r2q_mat_t;

    // Output beat
    typedef struct packed {
        logic signed [ELEM_W-1:0] quat_x;
        logic signed [ELEM_W-1:0] quat_y;
        logic signed [ELEM_W-1:0] quat_z;
        logic signed [ELEM_W-1:0] quat_w;
        path_t                    path_taken;
    } r2q_quat_t;

endpackage

// ===== sv/r2q_rsqrt.sv =====
// ----------------------------------------------------------------------------
// r2q_rsqrt
// Pipelined reciprocal square root: S = floor(sqrt(floor(2^EXP / T))).
// Restoring division, four quotient bits per stage, then digit-by-digit
// square root, two root bits per stage. A side payload travels along.
// ----------------------------------------------------------------------------
module r2q_rsqrt #(
    parameter int FRAC_BITS = 14,
    parameter int PLW       = 8,
    localparam int RS_BITS  = (63 - FRAC_BITS) / 2,
    localparam int EXP      = 2 * RS_BITS - 2 + FRAC_BITS,
    localparam int TW       = (FRAC_BITS >= 17) ? FRAC_BITS + 2 : 19,
    localparam int SW       = EXP / 2 + 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [TW-1:0] t,
    input  logic [PLW-1:0]       in_pl,
    output logic                 out_valid,
    output logic [SW-1:0]        s,
    output logic [PLW-1:0]       out_pl
);

    localparam int MW    = TW - 1;
    localparam int DSTEP = 4;
    localparam int NDIV  = (EXP + DSTEP) / DSTEP;
    localparam int DNW   = NDIV * DSTEP;
    localparam int DTOP  = DNW - 1 - EXP;
    localparam int SSTEP = 2;
    localparam int NP    = (EXP + 2) / 2;
    localparam int NSQ   = (NP + SSTEP - 1) / SSTEP;
    localparam int RDW   = 2 * NSQ * SSTEP;
    localparam int REMW  = SW + 3;

    // Non-positive t gives a zero scale
    logic t_zero;
    assign t_zero = t[TW-1] || (t == '0);

    // Division stage registers
    logic           dv_reg [NDIV];
    logic           dz_reg [NDIV];
    logic [MW-1:0]  dt_reg [NDIV];
    logic [MW-1:0]  dr_reg [NDIV];
    logic [DNW-1:0] dq_reg [NDIV];
    logic [PLW-1:0] dp_reg [NDIV];

    for (genvar g = 0; g < NDIV; g++) begin : g_div
        logic           v_in;
        logic           z_in;
        logic [MW-1:0]  t_in;
        logic [MW-1:0]  r_in;
        logic [DNW-1:0] q_in;
        logic [PLW-1:0] p_in;
        logic [MW-1:0]  r_next;
        logic [DNW-1:0] q_next;
        logic [MW:0]    rr;

        if (g == 0) begin : g_head
            always_comb
            begin
                v_in = in_valid;
                z_in = t_zero;
                t_in = t_zero ? MW'(1) : t[MW-1:0];
                r_in = '0;
                q_in = '0;
                p_in = in_pl;
            end
        end else begin : g_tail
            always_comb
            begin
                v_in = dv_reg[g-1];
                z_in = dz_reg[g-1];
                t_in = dt_reg[g-1];
                r_in = dr_reg[g-1];
                q_in = dq_reg[g-1];
                p_in = dp_reg[g-1];
            end
        end

        // Shift in dividend bits and subtract the divisor where it fits
        always_comb
        begin
            r_next = r_in;
            q_next = q_in;
            rr     = '0;
            for (int k = 0; k < DSTEP; k++)
            begin
                rr     = {r_next, ((g * DSTEP + k) == DTOP)};
                q_next = {q_next[DNW-2:0], (rr >= {1'b0, t_in})};
                if (rr >= {1'b0, t_in})
                begin
                    rr = rr - {1'b0, t_in};
                end
                r_next = rr[MW-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                dv_reg[g] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dz_reg[g] <= z_in;
                dt_reg[g] <= t_in;
                dr_reg[g] <= r_next;
                dq_reg[g] <= q_next;
                dp_reg[g] <= p_in;
            end
        end
    end

    // Square root stage registers
    logic            sv_reg   [NSQ];
    logic            sz_reg   [NSQ];
    logic [RDW-1:0]  srad_reg [NSQ];
    logic [SW-1:0]   sroot_reg[NSQ];
    logic [REMW-1:0] srem_reg [NSQ];
    logic [PLW-1:0]  sp_reg   [NSQ];

    for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
        logic            v_in;
        logic            z_in;
        logic [RDW-1:0]  rad_in;
        logic [SW-1:0]   root_in;
        logic [REMW-1:0] rem_in;
        logic [PLW-1:0]  p_in;
        logic [SW-1:0]   root_next;
        logic [REMW-1:0] rem_next;
        logic [REMW-1:0] nr;
        logic [REMW-1:0] trial;

        if (g == 0) begin : g_head
            always_comb
            begin
                v_in    = dv_reg[NDIV-1];
                z_in    = dz_reg[NDIV-1];
                rad_in  = RDW'(dq_reg[NDIV-1][EXP:0]);
                root_in = '0;
                rem_in  = '0;
                p_in    = dp_reg[NDIV-1];
            end
        end else begin : g_tail
            always_comb
            begin
                v_in    = sv_reg[g-1];
                z_in    = sz_reg[g-1];
                rad_in  = srad_reg[g-1];
                root_in = sroot_reg[g-1];
                rem_in  = srem_reg[g-1];
                p_in    = sp_reg[g-1];
            end
        end

        // Bring down two bit pairs, trying one root bit for each
        always_comb
        begin
            root_next = root_in;
            rem_next  = rem_in;
            nr        = '0;
            trial     = '0;
            for (int k = 0; k < SSTEP; k++)
            begin
                nr    = {rem_next[REMW-3:0], rad_in[RDW-1-2*(g*SSTEP+k) -: 2]};
                trial = REMW'({root_next, 2'b01});
                if (nr >= trial)
                begin
                    nr        = nr - trial;
                    root_next = {root_next[SW-2:0], 1'b1};
                end
                else
                begin
                    root_next = {root_next[SW-2:0], 1'b0};
                end
                rem_next = nr;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                sv_reg[g] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sz_reg[g]    <= z_in;
                srad_reg[g]  <= rad_in;
                sroot_reg[g] <= root_next;
                srem_reg[g]  <= rem_next;
                sp_reg[g]    <= p_in;
            end
        end
    end

    assign out_valid = sv_reg[NSQ-1];
    assign s         = sz_reg[NSQ-1] ? '0 : sroot_reg[NSQ-1];
    assign out_pl    = sp_reg[NSQ-1];

endmodule

// ===== sv/rotation_matrix_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Shepperd conversion of a 3x3 rotation matrix to a unit quaternion.
// ----------------------------------------------------------------------------
// Takes one matrix beat per cycle while mat_stall is low and returns one
// quaternion beat per matrix, in order. From accepted matrix to quat_valid a
// beat passes, at the default FRAC_BITS, the branch select and operand stages
// (2), the reciprocal square root divider (one stage per four quotient bits,
// 16) and root extractor (one stage per two root bits, 16), a multiply stage,
// a round and saturate stage, and the output register. Throughput is one beat
// per cycle while mat_stall is low; a skid register behind the output lets one
// more beat land while quat is stalled, after which mat_stall rises until the skid drains.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion
    import r2q_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      mat_valid,
    output logic      mat_stall,
    input  r2q_mat_t  mat,
    output logic      quat_valid,
    input  logic      quat_stall,
    output r2q_quat_t quat
);

    localparam int RS_BITS = (63 - FRAC_BITS) / 2;
    localparam int EXP     = 2 * RS_BITS - 2 + FRAC_BITS;
    localparam int TW      = (FRAC_BITS >= 17) ? FRAC_BITS + 2 : 19;
    localparam int SW      = EXP / 2 + 1;
    localparam int PW      = TW + SW + 1;
    localparam int SHW     = PW - RS_BITS + 1;
    localparam int PLW     = 4 * TW + 2;
    localparam logic signed [TW-1:0] ONE_Q  = TW'(1) << FRAC_BITS;
    localparam logic signed [PW:0]   HALF_Q = (PW+1)'(1) << (RS_BITS - 1);
    localparam logic signed [SHW-1:0] Q_MAX = SHW'(32767);
    localparam logic signed [SHW-1:0] Q_MIN = -SHW'(32768);

    // Round to nearest at RS_BITS (floor of value plus half), then saturate
    function automatic logic signed [ELEM_W-1:0] round_sat(input logic signed [PW-1:0] p);
        logic signed [PW:0]    sum;
        logic signed [SHW-1:0] sh;
        logic signed [ELEM_W-1:0] res;
        sum = (PW+1)'(p) + HALF_Q;
        sh  = SHW'(sum >>> RS_BITS);
        if (sh > Q_MAX)
        begin
            res = Q_MAX[ELEM_W-1:0];
        end
        else if (sh < Q_MIN)
        begin
            res = Q_MIN[ELEM_W-1:0];
        end
        else
        begin
            res = sh[ELEM_W-1:0];
        end
        return res;
    endfunction

    logic en;
    logic skid_valid_reg;

    // Pipeline moves whenever the skid register is empty
    assign en        = !skid_valid_reg;
    assign mat_stall = skid_valid_reg;

    // Stage A: trace sign and largest diagonal
    logic            a_valid_reg;
    r2q_mat_t        a_mat_reg;
    path_t           a_path_reg;
    logic signed [ELEM_W+1:0] trace;
    path_t           path_next;

    always_comb
    begin
        trace = (ELEM_W+2)'(mat.m00) + (ELEM_W+2)'(mat.m11) + (ELEM_W+2)'(mat.m22);
        if (trace > 0)
        begin
            path_next = PATH_TRACE;
        end
        else if (mat.m22 > ((mat.m11 > mat.m00) ? mat.m11 : mat.m00))
        begin
            path_next = PATH_Z;
        end
        else if (mat.m11 > mat.m00)
        begin
            path_next = PATH_Y;
        end
        else
        begin
            path_next = PATH_X;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= mat_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mat_reg  <= mat;
            a_path_reg <= path_next;
        end
    end

    // Stage B: t and the four operands for the chosen branch
    logic signed [TW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic signed [TW-1:0] t_next, ox_next, oy_next, oz_next, ow_next;
    logic                 b_valid_reg;
    logic signed [TW-1:0] b_t_reg;
    logic [PLW-1:0]       b_pl_reg;

    always_comb
    begin
        e00 = TW'(a_mat_reg.m00);
        e01 = TW'(a_mat_reg.m01);
        e02 = TW'(a_mat_reg.m02);
        e10 = TW'(a_mat_reg.m10);
        e11 = TW'(a_mat_reg.m11);
        e12 = TW'(a_mat_reg.m12);
        e20 = TW'(a_mat_reg.m20);
        e21 = TW'(a_mat_reg.m21);
        e22 = TW'(a_mat_reg.m22);
        case (a_path_reg)
            PATH_X:
            begin
                t_next  = e00 - (e11 + e22) + ONE_Q;
                ox_next = t_next;
                oy_next = e01 + e10;
                oz_next = e02 + e20;
                ow_next = e12 - e21;
            end
            PATH_Y:
            begin
                t_next  = e11 - (e22 + e00) + ONE_Q;
                ox_next = e10 + e01;
                oy_next = t_next;
                oz_next = e12 + e21;
                ow_next = e20 - e02;
            end
            PATH_Z:
            begin
                t_next  = e22 - (e00 + e11) + ONE_Q;
                ox_next = e20 + e02;
                oy_next = e21 + e12;
                oz_next = t_next;
                ow_next = e01 - e10;
            end
            default:
            begin
                t_next  = e00 + e11 + e22 + ONE_Q;
                ox_next = e12 - e21;
                oy_next = e20 - e02;
                oz_next = e01 - e10;
                ow_next = t_next;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_t_reg  <= t_next;
            b_pl_reg <= {ox_next, oy_next, oz_next, ow_next, a_path_reg};
        end
    end

    // Scale factor s = 0.5 / sqrt(t)
    logic           r_valid;
    logic [SW-1:0]  r_s;
    logic [PLW-1:0] r_pl;

    r2q_rsqrt #(
        .FRAC_BITS (FRAC_BITS),
        .PLW       (PLW)
    ) u_rsqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (b_valid_reg),
        .t         (b_t_reg),
        .in_pl     (b_pl_reg),
        .out_valid (r_valid),
        .s         (r_s),
        .out_pl    (r_pl)
    );

    // Stage C: four products with s
    logic signed [TW-1:0] r_ox, r_oy, r_oz, r_ow;
    logic signed [SW:0]   s_ext;
    logic                 c_valid_reg;
    logic signed [PW-1:0] c_px_reg, c_py_reg, c_pz_reg, c_pw_reg;
    path_t                c_path_reg;

    assign r_ox  = r_pl[4*TW+1 -: TW];
    assign r_oy  = r_pl[3*TW+1 -: TW];
    assign r_oz  = r_pl[2*TW+1 -: TW];
    assign r_ow  = r_pl[TW+1 -: TW];
    assign s_ext = {1'b0, r_s};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c_valid_reg <= r_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_px_reg   <= PW'(r_ox) * PW'(s_ext);
            c_py_reg   <= PW'(r_oy) * PW'(s_ext);
            c_pz_reg   <= PW'(r_oz) * PW'(s_ext);
            c_pw_reg   <= PW'(r_ow) * PW'(s_ext);
            c_path_reg <= r_pl[1:0];
        end
    end

    // Stage D: round and saturate
    logic      d_valid_reg;
    r2q_quat_t d_quat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_quat_reg.quat_x     <= round_sat(c_px_reg);
            d_quat_reg.quat_y     <= round_sat(c_py_reg);
            d_quat_reg.quat_z     <= round_sat(c_pz_reg);
            d_quat_reg.quat_w     <= round_sat(c_pw_reg);
            d_quat_reg.path_taken <= c_path_reg;
        end
    end

    // Output register and skid: park a beat in the skid while quat is stalled
    logic      out_valid_reg;
    r2q_quat_t out_quat_reg;
    r2q_quat_t skid_quat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !quat_stall)
        begin
            out_valid_reg  <= skid_valid_reg || d_valid_reg;
            skid_valid_reg <= 1'b0;
        end
        else if (en && d_valid_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !quat_stall)
        begin
            out_quat_reg <= skid_valid_reg ? skid_quat_reg : d_quat_reg;
        end
        if (out_valid_reg && quat_stall && en && d_valid_reg)
        begin
            skid_quat_reg <= d_quat_reg;
        end
    end

    assign quat_valid = out_valid_reg;
    assign quat       = out_quat_reg;

endmodule

// ===== sv/r2q_checker.sv =====
// ----------------------------------------------------------------------------
// r2q_sva
// Port-level checks for the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
`include "rotation_matrix_to_quaternion_assert.svh"

module r2q_sva
    import r2q_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      mat_stall,
    input logic      quat_valid,
    input logic      quat_stall,
    input r2q_quat_t quat
);

    // Hold a stalled output beat
    `R2Q_ASSERT_NEXT(a_quat_hold, quat_valid && quat_stall,
        quat_valid && $stable(quat), "quat beat changed while stalled")

    // The s*t component of the chosen branch is never negative
    `R2Q_ASSERT_NOW(a_main_sign, quat_valid,
        (quat.path_taken == PATH_TRACE && !quat.quat_w[15]) ||
        (quat.path_taken == PATH_X && !quat.quat_x[15]) ||
        (quat.path_taken == PATH_Y && !quat.quat_y[15]) ||
        (quat.path_taken == PATH_Z && !quat.quat_z[15]), "main component negative")

    // Input stall only follows a stalled output beat
    `R2Q_ASSERT_NOW(a_stall_cause, $rose(mat_stall),
        $past(quat_valid) && $past(quat_stall), "mat_stall rose without output back-pressure")

endmodule

bind rotation_matrix_to_quaternion r2q_sva u_r2q_sva (
    .clk        (clk),
    .rst_n      (rst_n),
    .mat_stall  (mat_stall),
    .quat_valid (quat_valid),
    .quat_stall (quat_stall),
    .quat       (quat)
);

// ===== tb/r2q_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// r2q_checker
// Watches both channels of the matrix to quaternion block, predicts each
// quaternion beat from the accepted matrix beat and compares field by field.
// ----------------------------------------------------------------------------
module r2q_checker
    import r2q_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      mat_valid,
    input  logic      mat_stall,
    input  r2q_mat_t  mat,
    input  logic      quat_valid,
    input  logic      quat_stall,
    input  r2q_quat_t quat,
    output int        fail_count,
    output int        quats_pending
);

    localparam int FRAC    = 14;
    localparam int RS      = (63 - FRAC) / 2;
    localparam longint ONE = longint'(1) << FRAC;

    r2q_quat_t quats_due[$];

    // Integer square root, floor
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        begin
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > n)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (n >= res + bitv)
                begin
                    n   = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        end
    endfunction

    // Scaled reciprocal root: floor(2^RS * 0.5 / sqrt(t)), zero for t <= 0
    function automatic longint recip_root(input longint t);
        longint unsigned num;
        begin
            if (t <= 0)
                return 0;
            num = 64'd1 << (2 * RS - 2 + FRAC);
            return longint'(int_sqrt(num / longint'(t)));
        end
    endfunction

    // Multiply by the scale, round half up at RS bits, saturate to 16 bits
    function automatic logic signed [ELEM_W-1:0] scale_sat(input longint p,
                                                           input longint s);
        longint r;
        begin
            r = (p * s + (longint'(1) << (RS - 1))) >>> RS;
            if (r > 32767)
                r = 32767;
            if (r < -32768)
                r = -32768;
            return r[ELEM_W-1:0];
        end
    endfunction

    function automatic r2q_quat_t quat_from_matrix(input r2q_mat_t m);
        longint a [3][3];
        longint el [9];
        logic signed [ELEM_W-1:0] q [4];
        longint trace, t, s;
        int i, j, k, r, c;
        r2q_quat_t res;
        begin
            el = '{m.m00, m.m01, m.m02, m.m10, m.m11, m.m12, m.m20, m.m21, m.m22};
            // Work on the transpose
            for (r = 0; r < 3; r++)
                for (c = 0; c < 3; c++)
                    a[c][r] = el[r * 3 + c];
            trace = a[0][0] + a[1][1] + a[2][2];
            if (trace > 0)
            begin
                t    = trace + ONE;
                s    = recip_root(t);
                q[3] = scale_sat(t, s);
                q[0] = scale_sat(a[2][1] - a[1][2], s);
                q[1] = scale_sat(a[0][2] - a[2][0], s);
                q[2] = scale_sat(a[1][0] - a[0][1], s);
                res.path_taken = PATH_TRACE;
            end
            else
            begin
                // Largest diagonal, ties keep the lower index
                i = 0;
                if (a[1][1] > a[0][0])
                    i = 1;
                if (a[2][2] > a[i][i])
                    i = 2;
                j = (i + 1) % 3;
                k = (j + 1) % 3;
                t = (a[i][i] - (a[j][j] + a[k][k])) + ONE;
                s = recip_root(t);
                if (s == 0)
                    t = 0;
                q[i] = scale_sat(t, s);
                q[3] = scale_sat(a[k][j] - a[j][k], s);
                q[j] = scale_sat(a[j][i] + a[i][j], s);
                q[k] = scale_sat(a[k][i] + a[i][k], s);
                res.path_taken = path_t'(i);
            end
            res.quat_x = q[0];
            res.quat_y = q[1];
            res.quat_z = q[2];
            res.quat_w = q[3];
            return res;
        end
    endfunction

    // Queue predictions on accepted matrix beats, compare accepted quat beats
    always @(posedge clk or negedge rst_n)
    begin
        r2q_quat_t want;
        if (!rst_n)
        begin
            fail_count    <= 0;
            quats_pending <= 0;
        end
        else
        begin
            if (mat_valid && !mat_stall)
                quats_due.push_back(quat_from_matrix(mat));
            if (quat_valid && !quat_stall)
            begin
                if (quats_due.size() == 0)
                begin
                    $error("quaternion beat with none expected");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = quats_due.pop_front();
                    if (quat.quat_x !== want.quat_x)
                        $error("quat_x expected %0d got %0d", want.quat_x, quat.quat_x);
                    if (quat.quat_y !== want.quat_y)
                        $error("quat_y expected %0d got %0d", want.quat_y, quat.quat_y);
                    if (quat.quat_z !== want.quat_z)
                        $error("quat_z expected %0d got %0d", want.quat_z, quat.quat_z);
                    if (quat.quat_w !== want.quat_w)
                        $error("quat_w expected %0d got %0d", want.quat_w, quat.quat_w);
                    if (quat.path_taken !== want.path_taken)
                        $error("path_taken expected %0d got %0d",
                               want.path_taken, quat.path_taken);
                    if (quat !== want)
                        fail_count <= fail_count + 1;
                end
            end
            quats_pending <= quats_due.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random matrices into the quaternion block with random
// idle bursts on both channels and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top
    import r2q_pkg::*;
;

    localparam int NUM_RANDOM = 1780;
    localparam int QUIET_TAIL = 200;
    localparam int DRAIN_CYC  = 60;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      mat_valid = 1'b0;
    logic      mat_stall;
    r2q_mat_t  mat = '0;
    logic      quat_valid;
    logic      quat_stall = 1'b0;
    r2q_quat_t quat;
    logic      quiet = 1'b0;
    int        fail_count;
    int        quats_pending;

    rotation_matrix_to_quaternion dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .mat_valid  (mat_valid),
        .mat_stall  (mat_stall),
        .mat        (mat),
        .quat_valid (quat_valid),
        .quat_stall (quat_stall),
        .quat       (quat)
    );

    r2q_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .mat_valid     (mat_valid),
        .mat_stall     (mat_stall),
        .mat           (mat),
        .quat_valid    (quat_valid),
        .quat_stall    (quat_stall),
        .quat          (quat),
        .fail_count    (fail_count),
        .quats_pending (quats_pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Present one matrix beat and hold it until accepted
    task automatic send_matrix(input r2q_mat_t m);
        begin
            mat       <= m;
            mat_valid <= 1'b1;
            do
                @(posedge clk);
            while (mat_stall);
            @(negedge clk);
        end
    endtask

    // Drop valid for a random burst now and then
    task automatic maybe_idle();
        begin
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                mat_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
        end
    endtask

    function automatic r2q_mat_t diag_matrix(input int d0, input int d1, input int d2);
        r2q_mat_t m;
        begin
            m     = '0;
            m.m00 = d0[15:0];
            m.m11 = d1[15:0];
            m.m22 = d2[15:0];
            return m;
        end
    endfunction

    // One element: full range, near unit range, or an extreme
    function automatic logic [15:0] rand_elem(input int style);
        begin
            case (style)
                0: return 16'($urandom);
                1: return 16'($urandom_range(0, 32768) - 16384);
                default: return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
            endcase
        end
    endfunction

    function automatic r2q_mat_t rand_matrix();
        r2q_mat_t m;
        int style;
        begin
            style = $urandom_range(0, 9);
            m     = {9{16'($urandom)}};
            m.m00 = rand_elem(style < 4 ? 0 : (style < 9 ? 1 : 2));
            m.m01 = rand_elem(style < 4 ? 0 : (style < 9 ? 1 : 2));
            m.m02 = rand_elem(style < 4 ? 0 : (style < 9 ? 1 : 2));
            m.m10 = rand_elem(style < 4 ? 0 : (style < 9 ? 1 : 2));
            m.m11 = rand_elem(style < 4 ? 0 : (style < 9 ? 1 : 2));
            m.m12 = rand_elem(style < 4 ? 0 : (style < 9 ? 1 : 2));
            m.m20 = rand_elem(style < 4 ? 0 : (style < 9 ? 1 : 2));
            m.m21 = rand_elem(style < 4 ? 0 : (style < 9 ? 1 : 2));
            m.m22 = rand_elem(style < 4 ? 0 : (style < 9 ? 1 : 2));
            return m;
        end
    endfunction

    // Stall the quaternion channel in random bursts, none in the tail
    always @(negedge clk)
    begin
        if (quiet)
            quat_stall <= 1'b0;
        else if (!quat_stall && $urandom_range(0, 6) == 0)
        begin
            quat_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(negedge clk);
            quat_stall <= 1'b0;
        end
    end

    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        r2q_mat_t m;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Identity, half turns about each axis, zero, ties and extremes
        send_matrix(diag_matrix(16384, 16384, 16384));
        send_matrix(diag_matrix(16384, -16384, -16384));
        send_matrix(diag_matrix(-16384, 16384, -16384));
        send_matrix(diag_matrix(-16384, -16384, 16384));
        send_matrix(diag_matrix(0, 0, 0));
        send_matrix(diag_matrix(-100, -100, -100));
        send_matrix(diag_matrix(-200, 0, 0));
        send_matrix(diag_matrix(-32768, -32768, -32768));
        send_matrix(diag_matrix(32767, 32767, 32767));
        send_matrix({9{16'h7fff}});
        send_matrix({9{16'h8000}});
        send_matrix({9{16'hffff}});
        m = diag_matrix(0, 0, 0);
        m.m01 = 16'h7fff; m.m10 = 16'h8000; m.m02 = 16'h8000;
        m.m20 = 16'h7fff; m.m12 = 16'h7fff; m.m21 = 16'h8000;
        send_matrix(m);
        m.m00 = 16'd1;
        send_matrix(m);
        m = diag_matrix(-32768, 32767, -32768);
        m.m12 = 16'h7fff; m.m21 = 16'h7fff; m.m01 = 16'h8000;
        send_matrix(m);
        // 90 degrees about z
        m = diag_matrix(0, 0, 16384);
        m.m01 = -16'sd16384; m.m10 = 16'sd16384;
        send_matrix(m);

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n == NUM_RANDOM / 2)
            begin
                // Hold off until the pipeline has fully drained
                mat_valid <= 1'b0;
                wait (quats_pending == 0);
                @(negedge clk);
            end
            if (n == NUM_RANDOM - QUIET_TAIL)
                quiet <= 1'b1;
            maybe_idle();
            send_matrix(rand_matrix());
        end
        mat_valid <= 1'b0;

        wait (quats_pending == 0);
        repeat (DRAIN_CYC) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/r2q_pkg.sv
sv/r2q_rsqrt.sv
sv/rotation_matrix_to_quaternion.sv
sv/r2q_checker.sv
tb/r2q_checker.sv
tb/tb_top.sv
